[src/ssfl_pkg.sv]
// shared constants, word types and codes of the slab slot free list
package ssfl_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_SLOTS    = 1024;
    localparam int LINK_BYTES   = 4;

    localparam int OFF_W   = 12;                       // byte offsets, object size
    localparam int SLOT_W  = $clog2(MAX_SLOTS + 1);    // slot index incl end code
    localparam int IDX_W   = $clog2(MAX_SLOTS);        // link memory address
    localparam int DIVS_W  = OFF_W + 1;                // divisor incl link bytes
    localparam int STEP_W  = $clog2(OFF_W);            // divider step counter

    localparam logic [OFF_W-1:0]  AVAIL_BYTES = OFF_W'(PAGE_BYTES - HEADER_BYTES);
    localparam logic [OFF_W-1:0]  RESET_OBJ_SIZE = OFF_W'(64);
    localparam logic [SLOT_W-1:0] IN_USE_MAX = '1;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_BELOW  = 2'd2;
    localparam logic [1:0] STATUS_BEYOND = 2'd3;

    typedef struct packed {
        logic             op;
        logic [OFF_W-1:0] free_offset;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  object_offset;
        logic [SLOT_W-1:0] in_use;
    } t_out_word;

    // classified command between front and back
    typedef struct packed {
        logic             op;
        logic             below;
        logic [OFF_W-1:0] rel;
    } t_cmd;

    // back to front status
    typedef struct packed {
        logic             ready;
        logic [OFF_W-1:0] data_start;
    } t_back_status;

endpackage

[src/ssfl_div.sv]
// iterative restoring divider, one quotient bit per cycle
module ssfl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ssfl_pkg::OFF_W-1:0]  i_dividend,
    input  logic [ssfl_pkg::DIVS_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [ssfl_pkg::OFF_W-1:0]  o_quotient
);

    logic                        r_busy;
    logic                        r_done;
    logic [ssfl_pkg::STEP_W-1:0] r_cnt;
    logic [ssfl_pkg::DIVS_W-1:0] r_rem;
    logic [ssfl_pkg::DIVS_W-1:0] r_dvs;
    logic [ssfl_pkg::OFF_W-1:0]  r_quo;
    logic [ssfl_pkg::DIVS_W:0]   trial;
    logic [ssfl_pkg::DIVS_W:0]   diff;
    logic                        ge;

    assign trial = {r_rem, r_quo[ssfl_pkg::OFF_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ssfl_pkg::STEP_W'(ssfl_pkg::OFF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[ssfl_pkg::DIVS_W-1:0] : trial[ssfl_pkg::DIVS_W-1:0];
            r_quo <= {r_quo[ssfl_pkg::OFF_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[src/ssfl_cmd_queue.sv]
// two-entry command queue between front and back
module ssfl_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssfl_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ssfl_pkg::t_cmd o_cmd
);

    ssfl_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[src/ssfl_front.sv]
// front stage: takes input words and classifies them against the data area
module ssfl_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    input  ssfl_pkg::t_in_word     i_in_word,
    output logic                   full,
    input  ssfl_pkg::t_back_status i_back_status,
    output logic                   o_cmd_push,
    output ssfl_pkg::t_cmd         o_cmd,
    input  logic                   i_cmd_full
);

    logic           r_valid;
    ssfl_pkg::t_cmd r_cmd;
    logic           take;
    logic           drain;

    assign drain = r_valid && !i_cmd_full;
    assign full  = !i_back_status.ready || (r_valid && i_cmd_full);
    assign take  = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.op    <= i_in_word.op;
            r_cmd.below <= i_in_word.free_offset < i_back_status.data_start;
            r_cmd.rel   <= i_in_word.free_offset - i_back_status.data_start;
        end
    end

    assign o_cmd_push = drain;
    assign o_cmd      = r_cmd;

endmodule

[src/ssfl_back.sv]
// back stage: slab rebuild, link memory, allocate and free execution, result queue
module ssfl_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ssfl_pkg::OFF_W-1:0] i_cfg_wdata,
    input  logic                       i_cmd_empty,
    input  ssfl_pkg::t_cmd             i_cmd,
    output logic                       o_cmd_pop,
    output ssfl_pkg::t_back_status     o_status,
    input  logic                       pop,
    output logic                       empty,
    output ssfl_pkg::t_out_word        o_out_word
);

    typedef enum logic [2:0] {
        S_RB_START,
        S_RB_DIV,
        S_SWEEP,
        S_IDLE,
        S_ALLOC,
        S_FREE_DIV
    } t_state;

    t_state                       r_state, n_state;
    logic [ssfl_pkg::OFF_W-1:0]   r_obj_size, n_obj_size;
    logic [ssfl_pkg::SLOT_W-1:0]  r_head, n_head;
    logic [ssfl_pkg::SLOT_W-1:0]  r_count, n_count;
    logic [ssfl_pkg::SLOT_W-1:0]  r_slot_total, n_slot_total;
    logic [ssfl_pkg::OFF_W-1:0]   r_data_start, n_data_start;
    logic [ssfl_pkg::IDX_W-1:0]   r_sweep, n_sweep;
    logic [ssfl_pkg::OFF_W-1:0]   r_prod, n_prod;
    ssfl_pkg::t_out_word          r_oq [2];
    logic                         r_oq_wp, r_oq_rp;
    logic [1:0]                   r_oq_cnt;

    logic [ssfl_pkg::SLOT_W-1:0]  r_chain [ssfl_pkg::MAX_SLOTS];
    logic [ssfl_pkg::SLOT_W-1:0]  r_rd_data;
    logic                         mem_we;
    logic [ssfl_pkg::IDX_W-1:0]   mem_waddr;
    logic [ssfl_pkg::SLOT_W-1:0]  mem_wdata;

    logic                         div_start;
    logic [ssfl_pkg::OFF_W-1:0]   div_dvd;
    logic [ssfl_pkg::DIVS_W-1:0]  div_dvs;
    logic                         div_done;
    logic [ssfl_pkg::OFF_W-1:0]   div_quo;

    logic [ssfl_pkg::OFF_W-1:0]   size_eff;
    logic                         res_push;
    ssfl_pkg::t_out_word          res;
    logic                         res_pop;
    logic                         cmd_take;
    logic [ssfl_pkg::SLOT_W-1:0]  slots;
    logic [2*ssfl_pkg::OFF_W-1:0] prod;

    ssfl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign size_eff = (r_obj_size == '0) ? ssfl_pkg::OFF_W'(1) : r_obj_size;
    assign prod     = size_eff * {{(ssfl_pkg::OFF_W - ssfl_pkg::IDX_W){1'b0}},
                                  r_head[ssfl_pkg::IDX_W-1:0]};
    assign slots    = (div_quo > ssfl_pkg::OFF_W'(ssfl_pkg::MAX_SLOTS))
                    ? ssfl_pkg::SLOT_W'(ssfl_pkg::MAX_SLOTS)
                    : ssfl_pkg::SLOT_W'(div_quo);

    assign cmd_take  = (r_state == S_IDLE) && !i_cmd_empty && (r_oq_cnt != 2'd2);
    assign o_cmd_pop = cmd_take;
    assign res_pop   = pop && (r_oq_cnt != 2'd0);

    always_comb begin
        n_state      = r_state;
        n_obj_size   = r_obj_size;
        n_head       = r_head;
        n_count      = r_count;
        n_slot_total = r_slot_total;
        n_data_start = r_data_start;
        n_sweep      = r_sweep;
        n_prod       = r_prod;
        res_push     = 1'b0;
        res.status        = ssfl_pkg::STATUS_OK;
        res.object_offset = '0;
        res.in_use        = r_count;
        div_start    = 1'b0;
        div_dvd      = i_cmd.rel;
        div_dvs      = {1'b0, size_eff};
        mem_we       = 1'b0;
        mem_waddr    = r_sweep;
        mem_wdata    = {1'b0, r_sweep} + 1'b1;

        case (r_state)
            S_RB_START: begin
                div_start = 1'b1;
                div_dvd   = ssfl_pkg::AVAIL_BYTES;
                div_dvs   = {1'b0, size_eff} + ssfl_pkg::DIVS_W'(ssfl_pkg::LINK_BYTES);
                n_state   = S_RB_DIV;
            end
            S_RB_DIV: begin
                if (div_done) begin
                    n_slot_total = slots;
                    n_data_start = ssfl_pkg::OFF_W'(ssfl_pkg::HEADER_BYTES)
                                 + ssfl_pkg::OFF_W'({slots, 2'b00});
                    n_sweep      = '0;
                    n_state      = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // links run i to i+1; the last one lands on the slot count, read as end
                mem_we  = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == ssfl_pkg::IDX_W'(ssfl_pkg::MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_take) begin
                    if (i_cmd.op == ssfl_pkg::OP_ALLOC) begin
                        if (r_head >= r_slot_total) begin
                            res_push   = 1'b1;
                            res.status = ssfl_pkg::STATUS_FULL;
                        end else begin
                            n_prod  = prod[ssfl_pkg::OFF_W-1:0];
                            n_state = S_ALLOC;
                        end
                    end else if (i_cmd.below) begin
                        res_push   = 1'b1;
                        res.status = ssfl_pkg::STATUS_BELOW;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_FREE_DIV;
                    end
                end
            end
            S_ALLOC: begin
                n_head  = r_rd_data;
                n_count = (r_count == ssfl_pkg::IN_USE_MAX) ? r_count : r_count + 1'b1;
                res_push          = 1'b1;
                res.object_offset = r_data_start + r_prod;
                res.in_use        = n_count;
                n_state           = S_IDLE;
            end
            S_FREE_DIV: begin
                if (div_done) begin
                    res_push = 1'b1;
                    if (div_quo >= {1'b0, r_slot_total}) begin
                        res.status = ssfl_pkg::STATUS_BEYOND;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = div_quo[ssfl_pkg::IDX_W-1:0];
                        mem_wdata  = r_head;
                        n_head     = div_quo[ssfl_pkg::SLOT_W-1:0];
                        n_count    = (r_count == '0) ? r_count : r_count - 1'b1;
                        res.in_use = n_count;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_RB_START;
            end
        endcase

        if (i_cfg_we) begin
            n_obj_size = i_cfg_wdata;
            n_head     = '0;
            n_count    = '0;
            n_state    = S_RB_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RB_START;
            r_obj_size <= ssfl_pkg::RESET_OBJ_SIZE;
            r_head     <= '0;
            r_count    <= '0;
            r_oq_wp    <= 1'b0;
            r_oq_rp    <= 1'b0;
            r_oq_cnt   <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_obj_size <= n_obj_size;
            r_head     <= n_head;
            r_count    <= n_count;
            if (res_push) begin
                r_oq_wp <= !r_oq_wp;
            end
            if (res_pop) begin
                r_oq_rp <= !r_oq_rp;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, res_push} - {1'b0, res_pop};
        end
        r_slot_total <= n_slot_total;
        r_data_start <= n_data_start;
        r_sweep      <= n_sweep;
        r_prod       <= n_prod;
        if (res_push) begin
            r_oq[r_oq_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_chain[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_chain[r_head[ssfl_pkg::IDX_W-1:0]];
    end

    assign o_status.ready      = r_state != S_RB_START && r_state != S_RB_DIV
                              && r_state != S_SWEEP;
    assign o_status.data_start = r_data_start;
    assign empty      = r_oq_cnt == 2'd0;
    assign o_out_word = r_oq[r_oq_rp];

endmodule

[src/slab_slot_free_list.sv]
// top level of the slab slot free list
//
// manages the object slots of one page-sized slab through a linked free list held
// in a 1024-entry link memory. a word with op allocate pops the head slot and returns
// its byte offset, or status full; a word with op free turns a byte offset into a
// slot index and pushes it back (offsets below the data area report below, offsets
// past the last slot report beyond). both sides look like queues: push/full in,
// empty/pop out, with a two-entry result queue so the next word is taken while a
// result still waits. words are run one at a time in the back end: an allocate
// passes through classify, link memory read and offset multiply, and result; a
// free waits on the 12-step shared divider that finds the slot index. after
// reset and after every object size write the block rebuilds the slab: a 12-step
// division for the slot count, then a sweep that relinks every memory entry, with
// full held high throughout. the object size may only be written while no word is
// in flight; a size of zero is taken as one
module slab_slot_free_list (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [ssfl_pkg::OFF_W-1:0] i_cfg_wdata,
    // input word queue
    input  logic                       push,
    output logic                       full,
    input  ssfl_pkg::t_in_word         i_in_word,
    // result word queue
    output logic                       empty,
    input  logic                       pop,
    output ssfl_pkg::t_out_word        o_out_word
);

    ssfl_pkg::t_back_status back_status;
    ssfl_pkg::t_cmd         front_cmd;
    ssfl_pkg::t_cmd         queue_cmd;
    logic                   cmd_push;
    logic                   cmd_full;
    logic                   cmd_pop;
    logic                   cmd_empty;

    // front: registers the word and flags frees below the data area
    ssfl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .i_in_word     (i_in_word),
        .full          (full),
        .i_back_status (back_status),
        .o_cmd_push    (cmd_push),
        .o_cmd         (front_cmd),
        .i_cmd_full    (cmd_full)
    );

    // decouples the front from the long free path
    ssfl_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (queue_cmd)
    );

    // back: rebuild, link memory, head and count, result queue
    ssfl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_status    (back_status),
        .pop         (pop),
        .empty       (empty),
        .o_out_word  (o_out_word)
    );

endmodule
